// File: rtl/lr_pkg.sv
// lr_pkg: shared types and constants of the line rasterizer
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR   = 2'd2;

    localparam int DIM_W   = 13;
    localparam int COLOR_W = 24;
    localparam int PIX_W   = 24;
    localparam int AREA_W  = 2 * DIM_W;

    localparam int FIFO_DEPTH = 2;

    // per-beat decode that travels from front to back with the coordinates
    typedef struct packed {
        logic is_start;
        logic step_x_neg;
        logic step_y_neg;
    } lr_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lr_front.sv
// lr_front: decodes the incoming beat and precomputes the line setup
// (step directions, deltas, initial error); depends on lr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lr_front
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                         command,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output lr_ctrl_t                          ctrl,
    output logic signed [COORD_BITS:0]        delta_x,
    output logic signed [COORD_BITS:0]        neg_delta_y,
    output logic signed [COORD_BITS+1:0]      error_init
);

    logic signed [COORD_BITS:0] x0_ext;
    logic signed [COORD_BITS:0] x1_ext;
    logic signed [COORD_BITS:0] y0_ext;
    logic signed [COORD_BITS:0] y1_ext;

    assign x0_ext = (COORD_BITS+1)'(start_x);
    assign x1_ext = (COORD_BITS+1)'(end_x);
    assign y0_ext = (COORD_BITS+1)'(start_y);
    assign y1_ext = (COORD_BITS+1)'(end_y);

    always_comb
    begin
        ctrl.is_start   = ~command;
        ctrl.step_x_neg = ~(start_x < end_x);
        ctrl.step_y_neg = ~(start_y < end_y);
        delta_x     = (end_x >= start_x) ? (x1_ext - x0_ext) : (x0_ext - x1_ext);
        neg_delta_y = (end_y >= start_y) ? (y0_ext - y1_ext) : (y1_ext - y0_ext);
        error_init  = (COORD_BITS+2)'(delta_x) + (COORD_BITS+2)'(neg_delta_y);
    end

endmodule

`default_nettype wire

// File: rtl/lr_fifo.sv
// lr_fifo: short queue between the decode front and the drawing back
// depends on lr_pkg for its depth
`timescale 1ns / 1ps
`default_nettype none

module lr_fifo
    import lr_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  not_empty
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full_reg, full_next;
    logic             push, pop;

    assign push      = wr_en && !full_reg;
    assign pop       = rd_en && (count_reg != '0);
    assign full      = full_reg;
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
        full_next = (count_next == CNT_W'(FIFO_DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            full_reg   <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("fifo count beyond depth");
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg == (count_reg == CNT_W'(FIFO_DEPTH)))
        else $error("fifo full flag out of step with count");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("fifo pointers differ while empty");

endmodule

`default_nettype wire

// File: rtl/lr_back.sv
// lr_back: bresenham stepper, offset multiply-add and output register
// depends on lr_pkg; fed from lr_fifo
`timescale 1ns / 1ps
`default_nettype none

module lr_back
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_pop,
    input  wire lr_ctrl_t                     in_ctrl,
    input  wire logic signed [COORD_BITS-1:0] in_x0,
    input  wire logic signed [COORD_BITS-1:0] in_y0,
    input  wire logic signed [COORD_BITS-1:0] in_x1,
    input  wire logic signed [COORD_BITS-1:0] in_y1,
    input  wire logic signed [COORD_BITS:0]   in_delta_x,
    input  wire logic signed [COORD_BITS:0]   in_neg_delta_y,
    input  wire logic signed [COORD_BITS+1:0] in_error,
    input  wire logic [DIM_W-1:0]             frame_width,
    input  wire logic [DIM_W-1:0]             frame_height,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic [PIX_W-1:0]                  out_offset,
    output logic                              out_write,
    output logic                              out_last
);

    localparam int CB     = COORD_BITS;
    localparam int ERR_W  = CB + 2;
    localparam int E2_W   = CB + 3;
    localparam int PROD_W = CB + DIM_W + 1;
    localparam int OFF_W  = PROD_W + 1;
    localparam int CMP_W  = (OFF_W > AREA_W) ? OFF_W : AREA_W;

    // line state
    logic                 busy_reg, busy_next;
    logic signed [CB-1:0] cur_x_reg, cur_x_next;
    logic signed [CB-1:0] cur_y_reg, cur_y_next;
    logic signed [CB-1:0] tgt_x_reg, tgt_x_next;
    logic signed [CB-1:0] tgt_y_reg, tgt_y_next;
    logic                 sx_neg_reg, sx_neg_next;
    logic                 sy_neg_reg, sy_neg_next;
    logic signed [CB:0]   dx_reg, dx_next;
    logic signed [CB:0]   ndy_reg, ndy_next;
    logic signed [ERR_W-1:0] err_reg, err_next;

    // multiply stage
    logic                     s1_valid_reg, s1_valid_next;
    logic signed [CB-1:0]     s1_x_reg, s1_x_next;
    logic signed [PROD_W-1:0] s1_prod_reg, s1_prod_next;
    logic                     s1_last_reg, s1_last_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_offset_reg, out_offset_next;
    logic             out_write_reg, out_write_next;
    logic             out_last_reg, out_last_next;

    logic [AREA_W-1:0] area_reg;

    logic                    advance;
    logic                    emit;
    logic                    done;
    logic                    x_move, y_move;
    logic signed [E2_W-1:0]  e2;
    logic signed [OFF_W-1:0] offset;
    logic                    in_frame;

    assign advance = !out_valid_reg || out_ready;
    assign in_pop  = advance && in_valid;
    assign emit    = in_pop && !in_ctrl.is_start && busy_reg;
    assign e2      = E2_W'(err_reg) <<< 1;

    // one bresenham step on the current point
    always_comb
    begin
        done   = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
        x_move = 1'b0;
        y_move = 1'b0;
        if (!done && (e2 >= E2_W'(ndy_reg)))
        begin
            if (cur_x_reg == tgt_x_reg)
            begin
                done = 1'b1;
            end
            else
            begin
                x_move = 1'b1;
            end
        end
        if (!done && (e2 <= E2_W'(dx_reg)))
        begin
            if (cur_y_reg == tgt_y_reg)
            begin
                done = 1'b1;
            end
            else
            begin
                y_move = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        dx_next     = dx_reg;
        ndy_next    = ndy_reg;
        err_next    = err_reg;
        if (in_pop && in_ctrl.is_start)
        begin
            busy_next   = 1'b1;
            cur_x_next  = in_x0;
            cur_y_next  = in_y0;
            tgt_x_next  = in_x1;
            tgt_y_next  = in_y1;
            sx_neg_next = in_ctrl.step_x_neg;
            sy_neg_next = in_ctrl.step_y_neg;
            dx_next     = in_delta_x;
            ndy_next    = in_neg_delta_y;
            err_next    = in_error;
        end
        else if (emit)
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (x_move)
                begin
                    cur_x_next = sx_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
                if (y_move)
                begin
                    cur_y_next = sy_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
                err_next = err_reg
                         + (x_move ? ERR_W'(ndy_reg) : ERR_W'(0))
                         + (y_move ? ERR_W'(dx_reg) : ERR_W'(0));
            end
        end
    end

    // y*width is registered before the add and the bounds check
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_x_next     = s1_x_reg;
        s1_prod_next  = s1_prod_reg;
        s1_last_next  = s1_last_reg;
        if (advance)
        begin
            s1_valid_next = emit;
            s1_x_next     = cur_x_reg;
            s1_prod_next  = cur_y_reg * $signed({1'b0, frame_width});
            s1_last_next  = done;
        end
    end

    assign offset   = OFF_W'(s1_x_reg) + OFF_W'(s1_prod_reg);
    assign in_frame = !offset[OFF_W-1]
                   && (CMP_W'($unsigned(offset)) < CMP_W'(area_reg));

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_offset_next = out_offset_reg;
        out_write_next  = out_write_reg;
        out_last_next   = out_last_reg;
        if (advance)
        begin
            out_valid_next  = s1_valid_reg;
            out_offset_next = in_frame ? PIX_W'($unsigned(offset)) : '0;
            out_write_next  = in_frame;
            out_last_next   = s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            sx_neg_reg    <= 1'b0;
            sy_neg_reg    <= 1'b0;
            dx_reg        <= '0;
            ndy_reg       <= '0;
            err_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            tgt_x_reg     <= tgt_x_next;
            tgt_y_reg     <= tgt_y_next;
            sx_neg_reg    <= sx_neg_next;
            sy_neg_reg    <= sy_neg_next;
            dx_reg        <= dx_next;
            ndy_reg       <= ndy_next;
            err_reg       <= err_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg       <= s1_x_next;
        s1_prod_reg    <= s1_prod_next;
        s1_last_reg    <= s1_last_next;
        out_offset_reg <= out_offset_next;
        out_write_reg  <= out_write_next;
        out_last_reg   <= out_last_next;
        area_reg       <= frame_width * frame_height;
    end

    assign out_valid  = out_valid_reg;
    assign out_offset = out_offset_reg;
    assign out_write  = out_write_reg;
    assign out_last   = out_last_reg;

    a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (s1_valid_reg && s1_last_reg))
        else $error("line ended without a last point");
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && $past(advance)) |-> $past(busy_reg))
        else $error("point produced while idle");
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_write_reg) |-> (out_offset_reg == '0))
        else $error("dropped point carries a nonzero offset");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid_reg && !out_ready) |-> $stable(s1_valid_reg))
        else $error("multiply stage moved under a stalled output");

endmodule

`default_nettype wire

// File: rtl/line_rasterizer.sv
// Line rasterizer: bresenham line generator for a linear frame buffer. A beat with
// tuser 0 loads a line's endpoints and produces nothing; each beat with tuser 1
// produces one point of the running line as offset x + y*frame_width with the draw
// color, tuser set when the offset lies inside the frame, tlast on the final point.
// A step beat with no line running produces nothing. The block takes one beat per
// cycle when the output is drained; the rate is set by the registered error-term
// update in the back stepper. A beat passes the queue, then the step and y*width
// multiply, then the add, bounds check and output register. The user must write
// configuration only while no line is drawn and the pipeline is empty; the block
// itself does not enforce this.
// depends on lr_pkg, lr_front, lr_fifo, lr_back
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COLOR_W-1:0]     cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // start_x, start_y, end_x, end_y, zero fill
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pixel_offset, pixel_color
    output logic [PIX_W+COLOR_W-1:0]    m_tdata,
    // write
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int CB      = COORD_BITS;
    localparam int CTRL_W  = $bits(lr_ctrl_t);
    localparam int ENTRY_W = CTRL_W + 4*CB + 2*(CB+1) + (CB+2);

    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [COLOR_W-1:0] draw_color_reg;

    lr_ctrl_t             f_ctrl;
    logic signed [CB:0]   f_dx;
    logic signed [CB:0]   f_ndy;
    logic signed [CB+1:0] f_err;

    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;

    lr_ctrl_t             b_ctrl;
    logic signed [CB-1:0] b_x0, b_y0, b_x1, b_y1;
    logic signed [CB:0]   b_dx, b_ndy;
    logic signed [CB+1:0] b_err;

    logic [PIX_W-1:0] out_offset;
    logic             out_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
            draw_color_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                CFG_DRAW_COLOR:   draw_color_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .command     (s_tuser),
        .start_x     ($signed(s_tdata[CB-1:0])),
        .start_y     ($signed(s_tdata[2*CB-1:CB])),
        .end_x       ($signed(s_tdata[3*CB-1:2*CB])),
        .end_y       ($signed(s_tdata[4*CB-1:3*CB])),
        .ctrl        (f_ctrl),
        .delta_x     (f_dx),
        .neg_delta_y (f_ndy),
        .error_init  (f_err)
    );

    assign wr_entry = {f_err, f_ndy, f_dx, s_tdata[4*CB-1:0], f_ctrl};
    assign s_tready = !q_full;

    lr_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (s_tvalid),
        .wr_data   (wr_entry),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (rd_entry),
        .not_empty (q_valid)
    );

    assign {b_err, b_ndy, b_dx, b_y1, b_x1, b_y0, b_x0, b_ctrl} = rd_entry;

    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (q_valid),
        .in_pop         (q_pop),
        .in_ctrl        (b_ctrl),
        .in_x0          (b_x0),
        .in_y0          (b_y0),
        .in_x1          (b_x1),
        .in_y1          (b_y1),
        .in_delta_x     (b_dx),
        .in_neg_delta_y (b_ndy),
        .in_error       (b_err),
        .frame_width    (frame_width_reg),
        .frame_height   (frame_height_reg),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_offset     (out_offset),
        .out_write      (out_write),
        .out_last       (m_tlast)
    );

    assign m_tdata = {draw_color_reg, out_offset};
    assign m_tuser = out_write;

endmodule

`default_nettype wire
